// ----- hw/rtl/life_cellular_automaton_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the life cellular automaton block
// Checks are compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_MACROS_SVH

`ifndef SYNTH
// property checked only while out of reset
`define LCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every edge, reset included
`define LCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/lca_pkg.sv -----
// ---------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the life cellular automaton block.
// ---------------------------------------------------------------------------
package lca_pkg;

    localparam int OP_W       = 2;
    localparam int CELL_ROW_W = 6;
    localparam int CELL_COL_W = 6;
    localparam int NBR_CNT_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_CLR  = 2'd1,
        OP_ADV  = 2'd2,
        OP_READ = 2'd3
    } op_t;

    // B3/S23 neighbour counts
    localparam logic [NBR_CNT_W-1:0] CNT_SURVIVE = 4'd2;
    localparam logic [NBR_CNT_W-1:0] CNT_BIRTH   = 4'd3;

endpackage

// ----- hw/rtl/lca_row_rule.sv -----
// ---------------------------------------------------------------------------
// lca_row_rule
// Next-generation value of one grid row from the old rows above, here and
// below; cells past either end of the row count as dead.
// ---------------------------------------------------------------------------
module lca_row_rule
    import lca_pkg::*;
#(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] above,
    input  logic [COLS-1:0] here,
    input  logic [COLS-1:0] below,
    output logic [COLS-1:0] next_row
);

    logic [COLS+1:0] above_ext;
    logic [COLS+1:0] here_ext;
    logic [COLS+1:0] below_ext;

    assign above_ext = {1'b0, above, 1'b0};
    assign here_ext  = {1'b0, here,  1'b0};
    assign below_ext = {1'b0, below, 1'b0};

    always_comb begin
        logic [NBR_CNT_W-1:0] cnt;
        for (int c = 0; c < COLS; c++) begin
            cnt = NBR_CNT_W'(above_ext[c]) + NBR_CNT_W'(above_ext[c+1])
                + NBR_CNT_W'(above_ext[c+2]) + NBR_CNT_W'(here_ext[c])
                + NBR_CNT_W'(here_ext[c+2]) + NBR_CNT_W'(below_ext[c])
                + NBR_CNT_W'(below_ext[c+1]) + NBR_CNT_W'(below_ext[c+2]);
            next_row[c] = (cnt == CNT_BIRTH) || (here[c] && (cnt == CNT_SURVIVE));
        end
    end

endmodule

// ----- hw/rtl/life_cellular_automaton.sv -----
// ---------------------------------------------------------------------------
// life_cellular_automaton
// Game of life (B3/S23) grid held in a row-wide synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request carries op, cell_row and cell_col.
//     op set/clear/read touches one cell; op advance steps the whole grid
//     one generation (no wrap, cells off the grid are dead).
//   Result channel m_*: one result per request, m_cell_live is the state of
//     the addressed cell after the request (0 when the address is off grid).
//   Sequence: a cell request goes through S_CELL, then S_OUT, to m_valid; an
//     advance goes through S_ADV, then S_OUT, with the single memory read
//     port streaming one row per cycle through the rule logic.
//   Throughput: one request at a time; s_ready is high only when no request
//     is in flight, so a new request is not taken before the last one is
//     through to the output register.
//   Reset: all cells read as dead at once (a per-row valid bit masks rows
//     never written since reset); no clearing pass.
//   Stall: the result sits in an output register; the next request is taken
//     while it waits, and finishes only when that register is free.
// ---------------------------------------------------------------------------
`include "life_cellular_automaton_macros.svh"

module life_cellular_automaton
    import lca_pkg::*;
#(
    parameter int GRID_ROWS = 36,
    parameter int GRID_COLS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [CELL_ROW_W-1:0] s_cell_row,
    input  logic [CELL_COL_W-1:0] s_cell_col,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_cell_live
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int CNT_W = $clog2(GRID_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CELL = 4'b0010,
        S_ADV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg;
    logic [CELL_ROW_W-1:0]   row_reg;
    logic [CELL_COL_W-1:0]   col_reg;
    logic                    row_on_reg, col_on_reg;
    logic [CNT_W-1:0]        seq_reg;
    logic [GRID_COLS-1:0]    above_reg, here_reg;
    logic                    res_reg;
    logic                    m_valid_reg, m_cell_live_reg;

    logic [GRID_COLS-1:0]    grid_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0]    row_valid_reg;
    logic [GRID_COLS-1:0]    rd_data_reg;
    logic                    rd_valid_reg;

    logic                    mem_rd_en, mem_wr_en;
    logic [ROW_W-1:0]        mem_rd_addr, mem_wr_addr;
    logic [GRID_COLS-1:0]    mem_wr_data;

    logic                    accept, out_free;
    logic                    s_row_on, s_col_on;
    logic [GRID_COLS-1:0]    row_word, cell_word, below_word, rule_row, bit_mask;
    logic [CNT_W-1:0]        rd_next, wr_row;
    logic                    seq_last, seq_first;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_cell_live = m_cell_live_reg;

    assign s_row_on = int'(s_cell_row) < GRID_ROWS;
    assign s_col_on = int'(s_cell_col) < GRID_COLS;

    assign row_word  = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask  = GRID_COLS'(1) << col_reg;
    assign rd_next   = seq_reg + CNT_W'(1);
    assign wr_row    = seq_reg - CNT_W'(1);
    assign seq_first = (seq_reg == '0);
    assign seq_last  = (int'(seq_reg) == GRID_ROWS);
    assign below_word = seq_last ? '0 : row_word;

    always_comb begin
        case (op_reg)
            OP_SET:  cell_word = row_word | bit_mask;
            OP_CLR:  cell_word = row_word & ~bit_mask;
            default: cell_word = row_word;
        endcase
    end

    lca_row_rule #(
        .COLS(GRID_COLS)
    ) u_rule (
        .above   (above_reg),
        .here    (here_reg),
        .below   (below_word),
        .next_row(rule_row)
    );

    // memory port control
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = ROW_W'(row_reg);
        mem_wr_data = cell_word;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (op_t'(s_op) == OP_ADV) begin
                        mem_rd_en = 1'b1;
                    end else begin
                        mem_rd_en   = s_row_on;
                        mem_rd_addr = ROW_W'(s_cell_row);
                    end
                end
            end
            S_CELL: begin
                mem_wr_en = row_on_reg && col_on_reg &&
                            (op_reg == OP_SET || op_reg == OP_CLR);
            end
            S_ADV: begin
                mem_rd_en   = int'(rd_next) < GRID_ROWS;
                mem_rd_addr = ROW_W'(rd_next);
                mem_wr_en   = !seq_first;
                mem_wr_addr = ROW_W'(wr_row);
                mem_wr_data = rule_row;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (op_t'(s_op) == OP_ADV) ? S_ADV : S_CELL;
                end
            end
            S_CELL: state_next = S_OUT;
            S_ADV: begin
                if (seq_last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // grid memory
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            grid_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg  <= grid_mem[mem_rd_addr];
            rd_valid_reg <= row_valid_reg[mem_rd_addr];
        end else begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (mem_wr_en) begin
            row_valid_reg[mem_wr_addr] <= 1'b1;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_reg     <= op_t'(s_op);
                    row_reg    <= s_cell_row;
                    col_reg    <= s_cell_col;
                    row_on_reg <= s_row_on;
                    col_on_reg <= s_col_on;
                    seq_reg    <= '0;
                    res_reg    <= 1'b0;
                end
            end
            S_CELL: begin
                res_reg <= row_on_reg && col_on_reg && |(cell_word & bit_mask);
            end
            S_ADV: begin
                seq_reg <= rd_next;
                if (seq_first) begin
                    above_reg <= '0;
                    here_reg  <= row_word;
                end else begin
                    above_reg <= here_reg;
                    here_reg  <= below_word;
                    if (row_on_reg && col_on_reg && int'(wr_row) == int'(row_reg)) begin
                        res_reg <= |(rule_row & bit_mask);
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_cell_live_reg <= res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    `LCA_ASSERT(a_out_from_done, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == S_OUT), "result raised outside completion")
    `LCA_ASSERT(a_wr_state, aclk, aresetn, mem_wr_en |-> (state_reg == S_CELL || state_reg == S_ADV), "grid written while idle")
    `LCA_ASSERT(a_rd_wr_apart, aclk, aresetn, (mem_wr_en && mem_rd_en) |-> (mem_rd_addr != mem_wr_addr), "row read and written in one cycle")
    `LCA_ASSERT(a_busy_after_req, aclk, aresetn, accept |=> !s_ready, "request taken while busy")
    `LCA_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (row_valid_reg == '0), "grid not cleared by reset")

endmodule

// ----- tb/sv/life_cellular_automaton_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// life_cellular_automaton_tb
// Self-checking bench for the B3/S23 grid. A shadow grid predicts the cell
// state returned for every request; directed corner and pattern requests
// come first, then random clusters that are seeded, stepped and probed,
// mixed with random-address noise that reaches off grid, under random idling on
// both channels and two long result stalls.
// ---------------------------------------------------------------------------
module life_cellular_automaton_tb;
    import lca_pkg::*;

    localparam int GRID_ROWS   = 36;
    localparam int GRID_COLS   = 64;
    localparam int RANDOM_REQS = 1950;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_CYC   = 60;

    typedef struct {
        op_t             op;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
        logic            live;
    } cell_expect_t;

    class life_grid_tracker;
        logic [GRID_COLS-1:0] grid [GRID_ROWS];
        cell_expect_t         pending_cells[$];
        int                   mismatches;
        int                   unexpected;
        int                   checked;
        int                   op_seen[4];
        int                   off_grid_seen;

        function new();
            foreach (grid[r]) grid[r] = '0;
            mismatches    = 0;
            unexpected    = 0;
            checked       = 0;
            off_grid_seen = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function bit bit_at(logic [GRID_COLS-1:0] word, int c);
            if (c < 0 || c >= GRID_COLS) return 1'b0;
            return word[c];
        endfunction

        function void next_generation();
            logic [GRID_COLS-1:0] prev [GRID_ROWS];
            logic [GRID_COLS-1:0] above, here, below;
            int                   cnt;
            foreach (grid[r]) prev[r] = grid[r];
            for (int r = 0; r < GRID_ROWS; r++) begin
                above = (r > 0) ? prev[r-1] : '0;
                here  = prev[r];
                below = (r + 1 < GRID_ROWS) ? prev[r+1] : '0;
                for (int c = 0; c < GRID_COLS; c++) begin
                    cnt = bit_at(above, c-1) + bit_at(above, c) + bit_at(above, c+1)
                        + bit_at(here, c-1) + bit_at(here, c+1)
                        + bit_at(below, c-1) + bit_at(below, c) + bit_at(below, c+1);
                    if (here[c])
                        grid[r][c] = (cnt == CNT_SURVIVE) || (cnt == CNT_BIRTH);
                    else
                        grid[r][c] = (cnt == CNT_BIRTH);
                end
            end
        endfunction

        function void note_request(op_t op, logic [CELL_ROW_W-1:0] row,
                                   logic [CELL_COL_W-1:0] col);
            cell_expect_t e;
            bit           on_grid;
            on_grid = (row < GRID_ROWS) && (col < GRID_COLS);
            op_seen[op]++;
            if (!on_grid) off_grid_seen++;
            case (op)
                OP_ADV: next_generation();
                OP_SET: if (on_grid) grid[row][col] = 1'b1;
                OP_CLR: if (on_grid) grid[row][col] = 1'b0;
                default: ;
            endcase
            e.op   = op;
            e.row  = row;
            e.col  = col;
            e.live = on_grid ? grid[row][col] : 1'b0;
            pending_cells.push_back(e);
        endfunction

        function void check_result(logic actual);
            cell_expect_t e;
            if (pending_cells.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result: cell_live %0b with no request pending",
                             actual);
                return;
            end
            e = pending_cells.pop_front();
            checked++;
            if (actual !== e.live) begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("cell_live mismatch: %s row %0d col %0d expected %0b got %0b",
                             e.op.name(), e.row, e.col, e.live, actual);
            end
        endfunction
    endclass

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op       = '0;
    logic [CELL_ROW_W-1:0] s_cell_row = '0;
    logic [CELL_COL_W-1:0] s_cell_col = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic                  m_cell_live;

    life_grid_tracker tracker;
    bit               quiet         = 1'b0;
    bit               stall_request = 1'b0;
    int               stalls_done   = 0;

    life_cellular_automaton #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_cell_row (s_cell_row),
        .s_cell_col (s_cell_col),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_live(m_cell_live)
    );

    always #2 aclk = ~aclk;

    // one request; valid stays up across back-to-back requests
    task automatic send_req(op_t op, int row, int col);
        logic [CELL_ROW_W-1:0] r6;
        logic [CELL_COL_W-1:0] c6;
        r6 = row[CELL_ROW_W-1:0];
        c6 = col[CELL_COL_W-1:0];
        if (!quiet && !stall_request && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_cell_row <= r6;
        s_cell_col <= c6;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(op, r6, c6);
    endtask

    // seed a 4x4 cluster, then step it and probe around it
    task automatic cluster_episode(ref int sent);
        int r0, c0, k, gens, sel;
        sel = $urandom_range(0, 3);
        r0  = (sel == 0) ? 0 : (sel == 1) ? GRID_ROWS - 4 : $urandom_range(0, GRID_ROWS - 1);
        sel = $urandom_range(0, 3);
        c0  = (sel == 0) ? 0 : (sel == 1) ? GRID_COLS - 4 : $urandom_range(0, GRID_COLS - 1);
        k   = $urandom_range(3, 8);
        repeat (k) begin
            send_req(OP_SET, r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3));
            sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
            send_req(OP_CLR, r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3));
            sent++;
        end
        gens = $urandom_range(1, 3);
        repeat (gens) begin
            send_req(OP_ADV, r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3));
            send_req(OP_READ, r0 + $urandom_range(0, 5) - 1, c0 + $urandom_range(0, 5) - 1);
            send_req(OP_READ, r0 + $urandom_range(0, 5) - 1, c0 + $urandom_range(0, 5) - 1);
            sent += 3;
        end
        if ($urandom_range(0, 7) == 0) begin
            for (int dr = 0; dr < 4; dr++)
                for (int dc = 0; dc < 4; dc++)
                    send_req(OP_CLR, r0 + dr, c0 + dc);
            sent += 16;
        end
    endtask

    task automatic noise_episode(ref int sent);
        repeat ($urandom_range(1, 6)) begin
            send_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
            sent++;
        end
    endtask

    // result side: random holds, one long stall on request, none when quiet
    initial begin
        int hold_left;
        logic nxt;
        hold_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) tracker.check_result(m_cell_live);
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b0;
            end else if (stall_request) begin
                hold_left = LONG_HOLD - 1;
                stalls_done++;
                stall_request = 1'b0;
                nxt = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(1, 17) - 1;
                nxt = 1'b0;
            end else begin
                nxt = 1'b1;
            end
            m_ready <= nxt;
        end
    end

    initial begin
        int sent;
        int next_stall;
        int failures;
        tracker = new();
        sent = 0;
        next_stall = 600;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners, off-grid addresses, edge patterns
        send_req(OP_SET, 0, 0);
        send_req(OP_READ, 0, 0);
        send_req(OP_SET, GRID_ROWS - 1, GRID_COLS - 1);
        send_req(OP_READ, GRID_ROWS - 1, GRID_COLS - 1);
        send_req(OP_CLR, 0, 0);
        send_req(OP_READ, 0, 0);
        send_req(OP_SET, GRID_ROWS, 5);
        send_req(OP_READ, GRID_ROWS, 5);
        send_req(OP_SET, 63, 63);
        send_req(OP_READ, 63, 63);
        send_req(OP_CLR, 40, 10);
        send_req(OP_READ, 0, GRID_COLS - 1);
        send_req(OP_ADV, GRID_ROWS - 1, GRID_COLS - 1);
        send_req(OP_SET, 0, 0);
        send_req(OP_SET, 0, 1);
        send_req(OP_SET, 0, 2);
        send_req(OP_ADV, 1, 1);
        send_req(OP_ADV, 63, 0);
        send_req(OP_READ, 0, 1);
        send_req(OP_SET, GRID_ROWS - 2, GRID_COLS - 2);
        send_req(OP_SET, GRID_ROWS - 2, GRID_COLS - 1);
        send_req(OP_SET, GRID_ROWS - 1, GRID_COLS - 2);
        send_req(OP_SET, GRID_ROWS - 1, GRID_COLS - 1);
        send_req(OP_ADV, GRID_ROWS - 1, GRID_COLS - 1);
        send_req(OP_READ, GRID_ROWS - 2, GRID_COLS - 2);

        while (sent < RANDOM_REQS) begin
            if (sent >= next_stall && next_stall < 1500) begin
                stall_request = 1'b1;
                next_stall += 700;
            end
            quiet = (sent >= RANDOM_REQS - 150);
            if ($urandom_range(0, 3) != 0)
                cluster_episode(sent);
            else
                noise_episode(sent);
        end
        s_valid <= 1'b0;

        while (tracker.pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        $display("covered %0d requests: %0d set, %0d clear, %0d advance, %0d read",
                 tracker.checked, tracker.op_seen[OP_SET], tracker.op_seen[OP_CLR],
                 tracker.op_seen[OP_ADV], tracker.op_seen[OP_READ]);
        $display("%0d off-grid addresses, %0d long result stalls, %0d mismatches",
                 tracker.off_grid_seen, stalls_done, tracker.mismatches);
        failures = tracker.mismatches + tracker.unexpected + tracker.pending_cells.size();
        if (failures == 0) begin
            $display("life_cellular_automaton verification clean");
        end else begin
            $display("life_cellular_automaton verification failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("life_cellular_automaton verification failed");
        $finish;
    end

endmodule
